// ----- rtl/rtpl_pkg.sv -----
`default_nettype none
package rtpl_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PAYLOAD_TYPE  = 3'd0;
    localparam logic [2:0] REG_SSRC          = 3'd1;
    localparam logic [2:0] REG_INIT_SEQ      = 3'd2;
    localparam logic [2:0] REG_CHANNELS      = 3'd3;
    localparam logic [2:0] REG_NS_PER_SAMPLE = 3'd4;
    localparam logic [2:0] REG_SAMPLES_PKT   = 3'd5;
    localparam logic [2:0] REG_MAX_PKT_BYTES = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [6:0]  RST_PAYLOAD_TYPE  = 7'd96;
    localparam logic [31:0] RST_SSRC          = 32'd0;
    localparam logic [15:0] RST_INIT_SEQ      = 16'd0;
    localparam logic [6:0]  RST_CHANNELS      = 7'd2;
    localparam logic [29:0] RST_NS_PER_SAMPLE = 30'd20833;
    localparam logic [15:0] RST_SAMPLES_PKT   = 16'd192;
    localparam logic [13:0] RST_MAX_PKT_BYTES = 14'd1500;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_OPEN  = 2'd2;

    // opcodes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [18:0] HDR_BYTES        = 19'd12;
    localparam logic [3:0]  HDR_LAST_IDX     = 4'd11;
    localparam logic [3:0]  SAMPLE_LAST_IDX  = 4'd2;
    localparam logic [22:0] L24_SCALE        = 23'd8388607;
    localparam logic [31:0] Q30_ONE          = 32'h4000_0000;

    typedef enum logic [1:0] {
        KIND_ERR    = 2'd0,
        KIND_HDR    = 2'd1,
        KIND_SAMPLE = 2'd2
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic check;
        logic mul;
        logic load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic opcode;
        logic ptp_pos;
        logic open;
        logic div_done;
        logic out_free;
        logic last_byte;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/rtpl_in_if.sv -----
`default_nettype none
interface rtpl_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [9:0]         frame_count;
    logic signed [63:0] ptp_time_ns;
    logic signed [31:0] sample;

    modport source (output valid, opcode, frame_count, ptp_time_ns, sample, input ready);
    modport sink (input valid, opcode, frame_count, ptp_time_ns, sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/rtpl_out_if.sv -----
`default_nettype none
interface rtpl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_packet;
    logic [1:0] status;

    modport source (output valid, out_byte, last_of_item, end_of_packet, status, input ready);
    modport sink (input valid, out_byte, last_of_item, end_of_packet, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/rtpl_div.sv -----
`default_nettype none
module rtpl_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [62:0] dividend,
    input  wire logic [29:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    localparam logic [5:0] LAST_STEP = 6'd62;

    logic [62:0] rq_reg, rq_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [30:0] shifted;
    logic [30:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle
    assign shifted  = {rem_reg, rq_reg[62]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[29:0] : shifted[29:0];
    assign rq_next  = {rq_reg[61:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= (divisor == '0) ? 30'd1 : divisor;
        end
        else if (busy_reg)
        begin
            rq_reg  <= rq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = rq_reg[31:0];
endmodule
`default_nettype wire

// ----- rtl/rtpl_datapath.sv -----
`default_nettype none
module rtpl_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rtpl_pkg::cmd_t                  cmd,
    output rtpl_pkg::stat_t                      stat,
    input  wire logic                            in_opcode,
    input  wire logic [9:0]                      in_frame_count,
    input  wire logic signed [63:0]              in_ptp_time_ns,
    input  wire logic signed [31:0]              in_sample,
    input  wire logic                            cfg_we,
    input  wire logic [rtpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtpl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [7:0]                           out_byte,
    output logic                                 out_last,
    output logic                                 out_eop,
    output logic [1:0]                           out_status
);
    import rtpl_pkg::*;

    // configuration
    logic [6:0]  pt_reg;
    logic [31:0] ssrc_reg;
    logic [6:0]  ch_reg;
    logic [29:0] nps_reg;
    logic [15:0] spp_reg;
    logic [13:0] max_reg;

    // packet state
    logic [31:0] ts_reg;
    logic [15:0] seq_reg;
    logic        open_reg;
    logic [15:0] left_reg;

    // per-item working registers
    kind_t       kind_reg;
    logic [1:0]  code_reg;
    logic        eop_reg;
    logic [3:0]  idx_reg;
    logic [31:0] hdr_ts_reg;
    logic [15:0] hdr_seq_reg;
    logic [9:0]  frames_reg;
    logic        ptp_pos_reg;
    logic [30:0] mag_reg;
    logic        neg_reg;
    logic [22:0] l24_reg;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_eop_reg;
    logic [1:0]  out_status_reg;

    logic        ptp_pos;
    logic [31:0] abs_in;
    logic [30:0] mag_in;
    logic [31:0] quot;
    logic        div_done;
    logic [31:0] du;
    logic signed [33:0] d_s;
    logic signed [33:0] lo_s;
    logic signed [33:0] hi_s;
    logic        resync;
    logic [31:0] ts_eff;
    logic [16:0] count;
    logic [18:0] pkt_len;
    logic        too_long;
    logic [53:0] prod;
    logic [23:0] l24_val;
    logic        last_byte;
    logic [7:0]  byte_sel;
    logic        out_free;

    assign ptp_pos = !in_ptp_time_ns[63] && (in_ptp_time_ns != '0);

    // clamp to plus or minus one and take the magnitude
    assign abs_in = in_sample[31] ? (~in_sample + 32'd1) : in_sample;
    assign mag_in = (abs_in > Q30_ONE) ? Q30_ONE[30:0] : abs_in[30:0];

    rtpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (in_ptp_time_ns[62:0]),
        .divisor  (nps_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // resync window: -spp <= d <= 2*spp keeps the running timestamp
    assign du     = quot - ts_reg;
    assign d_s    = $signed({{2{du[31]}}, du});
    assign lo_s   = -$signed({18'd0, spp_reg});
    assign hi_s   = $signed({17'd0, spp_reg, 1'b0});
    assign resync = ptp_pos_reg && ((d_s < lo_s) || (d_s > hi_s));
    assign ts_eff = resync ? quot : ts_reg;

    assign count    = 17'(frames_reg) * 17'(ch_reg);
    assign pkt_len  = HDR_BYTES + 19'(count) + 19'({count, 1'b0});
    assign too_long = pkt_len > 19'(max_reg);

    assign prod    = 54'(mag_reg) * 54'(L24_SCALE);
    assign l24_val = neg_reg ? (24'd0 - {1'b0, l24_reg}) : {1'b0, l24_reg};

    always_comb
    begin
        byte_sel  = 8'd0;
        last_byte = 1'b1;
        case (kind_reg)
            KIND_HDR:
            begin
                last_byte = (idx_reg == HDR_LAST_IDX);
                case (idx_reg)
                    4'd0:    byte_sel = RTP_VERSION_BYTE;
                    4'd1:    byte_sel = {1'b0, pt_reg};
                    4'd2:    byte_sel = hdr_seq_reg[15:8];
                    4'd3:    byte_sel = hdr_seq_reg[7:0];
                    4'd4:    byte_sel = hdr_ts_reg[31:24];
                    4'd5:    byte_sel = hdr_ts_reg[23:16];
                    4'd6:    byte_sel = hdr_ts_reg[15:8];
                    4'd7:    byte_sel = hdr_ts_reg[7:0];
                    4'd8:    byte_sel = ssrc_reg[31:24];
                    4'd9:    byte_sel = ssrc_reg[23:16];
                    4'd10:   byte_sel = ssrc_reg[15:8];
                    4'd11:   byte_sel = ssrc_reg[7:0];
                    default: byte_sel = 8'd0;
                endcase
            end
            KIND_SAMPLE:
            begin
                last_byte = (idx_reg == SAMPLE_LAST_IDX);
                case (idx_reg)
                    4'd0:    byte_sel = l24_val[23:16];
                    4'd1:    byte_sel = l24_val[15:8];
                    default: byte_sel = l24_val[7:0];
                endcase
            end
            default:
            begin
                byte_sel  = 8'd0;
                last_byte = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg        <= RST_PAYLOAD_TYPE;
            ssrc_reg      <= RST_SSRC;
            ch_reg        <= RST_CHANNELS;
            nps_reg       <= RST_NS_PER_SAMPLE;
            spp_reg       <= RST_SAMPLES_PKT;
            max_reg       <= RST_MAX_PKT_BYTES;
            ts_reg        <= '0;
            seq_reg       <= RST_INIT_SEQ;
            open_reg      <= 1'b0;
            left_reg      <= '0;
            kind_reg      <= KIND_ERR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                idx_reg <= '0;
                if (in_opcode == OP_SAMPLE)
                begin
                    kind_reg <= open_reg ? KIND_SAMPLE : KIND_ERR;
                end
            end

            if (cmd.check)
            begin
                if (too_long)
                begin
                    kind_reg <= KIND_ERR;
                    ts_reg   <= ts_eff;
                end
                else
                begin
                    kind_reg <= KIND_HDR;
                    seq_reg  <= seq_reg + 16'd1;
                    ts_reg   <= ts_eff + 32'(spp_reg);
                    left_reg <= count[15:0];
                    open_reg <= (count[15:0] != '0);
                end
            end

            if (cmd.mul)
            begin
                left_reg <= left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    open_reg <= 1'b0;
                end
            end

            if (cmd.load)
            begin
                idx_reg <= idx_reg + 4'd1;
            end

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PAYLOAD_TYPE:  pt_reg   <= cfg_data[6:0];
                    REG_SSRC:          ssrc_reg <= cfg_data;
                    REG_INIT_SEQ:      seq_reg  <= cfg_data[15:0];
                    REG_CHANNELS:      ch_reg   <= cfg_data[6:0];
                    REG_NS_PER_SAMPLE: nps_reg  <= cfg_data[29:0];
                    REG_SAMPLES_PKT:   spp_reg  <= cfg_data[15:0];
                    REG_MAX_PKT_BYTES: max_reg  <= cfg_data[13:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frames_reg  <= in_frame_count;
            ptp_pos_reg <= ptp_pos;
            mag_reg     <= mag_in;
            neg_reg     <= in_sample[31];
            code_reg    <= open_reg ? ST_OK : ST_NO_OPEN;
            eop_reg     <= 1'b0;
        end
        if (cmd.check)
        begin
            code_reg    <= too_long ? ST_TOO_LONG : ST_OK;
            eop_reg     <= (count[15:0] == '0);
            hdr_ts_reg  <= ts_eff;
            hdr_seq_reg <= seq_reg;
        end
        if (cmd.mul)
        begin
            l24_reg <= prod[52:30];
            eop_reg <= (left_reg == 16'd1);
        end
        if (cmd.load)
        begin
            out_byte_reg   <= byte_sel;
            out_last_reg   <= last_byte;
            out_eop_reg    <= last_byte && eop_reg && (kind_reg != KIND_ERR);
            out_status_reg <= code_reg;
        end
    end

    assign stat.opcode    = in_opcode;
    assign stat.ptp_pos   = ptp_pos;
    assign stat.open      = open_reg;
    assign stat.div_done  = div_done;
    assign stat.out_free  = out_free;
    assign stat.last_byte = last_byte;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_eop    = out_eop_reg;
    assign out_status = out_status_reg;
endmodule
`default_nettype wire

// ----- rtl/rtpl_ctrl.sv -----
`default_nettype none
module rtpl_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rtpl_pkg::stat_t stat,
    output rtpl_pkg::cmd_t       cmd
);
    import rtpl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_CHECK = 5'b00100,
        S_MUL   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.capture   = accept;
        cmd.div_start = accept && (stat.opcode == OP_START) && stat.ptp_pos;
        cmd.check     = (state_reg == S_CHECK);
        cmd.mul       = (state_reg == S_MUL);
        cmd.load      = (state_reg == S_EMIT) && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.opcode == OP_START)
                    begin
                        state_next = stat.ptp_pos ? S_DIV : S_CHECK;
                    end
                    else
                    begin
                        state_next = stat.open ? S_MUL : S_EMIT;
                    end
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = S_EMIT;
            S_MUL:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (stat.out_free && stat.last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rtp_l24_packetizer.sv -----
`default_nettype none
// RTP L24 packetizer: one item at a time, results leave through a one-entry output register.
// Sample item: capture, multiply, then 3 bytes before the input is free again.
// Start item: capture, length check, then 12 header bytes, with the bit-serial divider
// run first when the PTP time is above zero; an oversize start emits one error byte.
// A sample with no open packet emits one error byte. Output stalls hold the byte stream.
// Reset (rst_n low, asynchronous) loads the register defaults and clears all packet state.
module rtp_l24_packetizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rtpl_in_if.sink                              din,
    rtpl_out_if.source                           dout,
    input  wire logic                            cfg_we,
    input  wire logic [rtpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtpl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtpl_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    // The controller sequences each item: a start transfer optionally runs the divider, then
    // checks the packet length and commits the timestamp, and the sequence if it fits; a
    // sample with an open packet runs the scaling multiply; bytes go to the output register.
    rtpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the configuration, packet state, divider, multiplier and output register.
    rtpl_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_opcode      (din.opcode),
        .in_frame_count (din.frame_count),
        .in_ptp_time_ns (din.ptp_time_ns),
        .in_sample      (din.sample),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (dout.ready),
        .out_valid      (dout.valid),
        .out_byte       (dout.out_byte),
        .out_last       (dout.last_of_item),
        .out_eop        (dout.end_of_packet),
        .out_status     (dout.status)
    );

    assign din.ready = in_ready;
endmodule
`default_nettype wire
